FILE: rtl/rab_pkg.sv
// Shared types, constants and arithmetic helpers for the rotated box refit block.
// No dependencies; every other rtl file except rab_queue imports this package.
`default_nettype none
package rab_pkg;

  localparam int RW = 20;          // sine/cosine and matrix entries
  localparam int ZW = 20;          // CORDIC angle accumulator
  localparam int AW = 22;          // angle range reduction
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT = 18;  // reduce + 16 rotations + sign fix
  localparam int PW = RW + 32;     // matrix entry times coordinate
  localparam int SW = PW + 2;      // sum of three such products

  localparam logic signed [AW-1:0] PI_Q16      = 22'sd205887;
  localparam logic signed [AW-1:0] TWO_PI_Q16  = 22'sd411775;
  localparam logic signed [AW-1:0] HALF_PI_Q16 = 22'sd102944;
  localparam logic signed [RW-1:0] GAIN_Q16    = 20'sd39797;

  typedef logic signed [RW-1:0] rot_t;
  typedef logic signed [31:0]   q16_t;
  typedef logic signed [15:0]   ang_t;

  typedef enum logic [2:0] {
    CFG_MIN_X, CFG_MIN_Y, CFG_MIN_Z, CFG_MAX_X, CFG_MAX_Y, CFG_MAX_Z
  } cfg_idx_t;

  typedef struct packed {
    q16_t [2:0] scl;
    q16_t [2:0] sh;
  } xf_t;

  typedef struct packed {
    ang_t [2:0] ang;
    xf_t        xf;
  } in_item_t;

  typedef struct packed {
    rot_t [8:0] r;   // row-major, r[3*i+j]
    xf_t        xf;
  } rot_item_t;

  typedef struct packed {
    q16_t [2:0] lo;
    q16_t [2:0] hi;
  } base_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
    logic signed [ZW-1:0] t;
    unique case (i)
      4'd0:    t = 20'sd51472;
      4'd1:    t = 20'sd30386;
      4'd2:    t = 20'sd16055;
      4'd3:    t = 20'sd8150;
      4'd4:    t = 20'sd4091;
      4'd5:    t = 20'sd2047;
      4'd6:    t = 20'sd1024;
      4'd7:    t = 20'sd512;
      4'd8:    t = 20'sd256;
      4'd9:    t = 20'sd128;
      4'd10:   t = 20'sd64;
      4'd11:   t = 20'sd32;
      4'd12:   t = 20'sd16;
      4'd13:   t = 20'sd8;
      4'd14:   t = 20'sd4;
      default: t = 20'sd2;
    endcase
    return t;
  endfunction

  // rounded Q16 product of two matrix-range values
  function automatic rot_t mulq_r(input rot_t a, input rot_t b);
    logic signed [2*RW-1:0] p;
    p = (2*RW)'(a) * (2*RW)'(b) + 40'sd32768;
    return p[RW+15:16];
  endfunction

  function automatic q16_t sat32(input logic signed [63:0] v);
    q16_t s;
    if (v > 64'sd2147483647)       s = 32'sh7fffffff;
    else if (v < -64'sd2147483648) s = 32'sh80000000;
    else                           s = v[31:0];
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rab_cordic.sv
// One pipelined sine/cosine lane: range reduction, 16 rotation stages, sign fix.
// Depends on rab_pkg. One angle per cycle.
`default_nettype none
module rab_cordic (
  input  logic         clk,
  input  rab_pkg::ang_t ang,
  output rab_pkg::rot_t sn,
  output rab_pkg::rot_t cs
);
  import rab_pkg::*;

  logic signed [AW-1:0] a_nxt;
  logic                 neg_nxt;
  logic signed [RW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [RW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [0:CORDIC_STEPS-1];
  logic                 neg_r [0:CORDIC_STEPS];
  rot_t                 sn_r, cs_r;

  // fold into [-pi/2, pi/2], remembering a half-turn flip
  always_comb begin
    a_nxt = {{(AW-20){ang[15]}}, ang, 4'b0000};
    for (int k = 0; k < 2; k++) begin
      if (a_nxt > PI_Q16)  a_nxt = a_nxt - TWO_PI_Q16;
      if (a_nxt < -PI_Q16) a_nxt = a_nxt + TWO_PI_Q16;
    end
    neg_nxt = 1'b0;
    if (a_nxt > HALF_PI_Q16) begin
      a_nxt   = a_nxt - PI_Q16;
      neg_nxt = 1'b1;
    end else if (a_nxt < -HALF_PI_Q16) begin
      a_nxt   = a_nxt + PI_Q16;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= GAIN_Q16;
    y_r[0]   <= '0;
    z_r[0]   <= a_nxt[ZW-1:0];
    neg_r[0] <= neg_nxt;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (!z_r[g][ZW-1]) begin
        x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
      end else begin
        x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
      end
      neg_r[g+1] <= neg_r[g];
    end
    if (g < CORDIC_STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (!z_r[g][ZW-1]) z_r[g+1] <= z_r[g] - atan_lut(4'(g));
        else               z_r[g+1] <= z_r[g] + atan_lut(4'(g));
      end
    end
  end

  always_ff @(posedge clk) begin
    cs_r <= neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    sn_r <= neg_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
  end

  assign sn = sn_r;
  assign cs = cs_r;
endmodule
`default_nettype wire

FILE: rtl/rab_front.sv
// Front end: three CORDIC lanes and two product stages that build R = Rx*Ry*Rz.
// Depends on rab_pkg and rab_cordic. One item per cycle.
`default_nettype none
module rab_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rab_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rab_pkg::rot_item_t out_item
);
  import rab_pkg::*;

  localparam int VL = CORDIC_LAT + 2;

  rot_t sx, cx, sy, cy, sz, cz;
  logic v_r [0:VL-1];
  xf_t  xf_r [0:CORDIC_LAT-1];
  xf_t  xf1_r;
  rot_t sxsy_r, cxsy_r, cycz_r, cysz_r, sxcy_r, cxcz_r, cxsz_r, sxsz_r, sxcz_r, cxcy_r;
  rot_t sy1_r, sz1_r, cz1_r;
  rot_item_t item_r;

  rab_cordic u_cx (.clk(clk), .ang(in_item.ang[0]), .sn(sx), .cs(cx));
  rab_cordic u_cy (.clk(clk), .ang(in_item.ang[1]), .sn(sy), .cs(cy));
  rab_cordic u_cz (.clk(clk), .ang(in_item.ang[2]), .sn(sz), .cs(cz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VL; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 1; i < VL; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    xf_r[0] <= in_item.xf;
    for (int i = 1; i < CORDIC_LAT; i++) xf_r[i] <= xf_r[i-1];
    // first products
    xf1_r  <= xf_r[CORDIC_LAT-1];
    sxsy_r <= mulq_r(sx, sy);
    cxsy_r <= mulq_r(cx, sy);
    cycz_r <= mulq_r(cy, cz);
    cysz_r <= mulq_r(cy, sz);
    sxcy_r <= mulq_r(sx, cy);
    cxcz_r <= mulq_r(cx, cz);
    cxsz_r <= mulq_r(cx, sz);
    sxsz_r <= mulq_r(sx, sz);
    sxcz_r <= mulq_r(sx, cz);
    cxcy_r <= mulq_r(cx, cy);
    sy1_r  <= sy;
    sz1_r  <= sz;
    cz1_r  <= cz;
    // triple products and row sums
    item_r.xf   <= xf1_r;
    item_r.r[0] <= cycz_r;
    item_r.r[1] <= -cysz_r;
    item_r.r[2] <= sy1_r;
    item_r.r[3] <= mulq_r(sxsy_r, cz1_r) + cxsz_r;
    item_r.r[4] <= cxcz_r - mulq_r(sxsy_r, sz1_r);
    item_r.r[5] <= -sxcy_r;
    item_r.r[6] <= sxsz_r - mulq_r(cxsy_r, cz1_r);
    item_r.r[7] <= mulq_r(cxsy_r, sz1_r) + sxcz_r;
    item_r.r[8] <= cxcy_r;
  end

  assign out_valid = v_r[VL-1];
  assign out_item  = item_r;
endmodule
`default_nettype wire

FILE: rtl/rab_queue.sv
// Small FIFO between front and back end, register array with one read port.
// Depends on nothing but its parameters.
`default_nettype none
module rab_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);
  localparam int PTW = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [0:DEPTH-1];
  logic [PTW-1:0] wr_r, rd_r;
  logic [CW-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PTW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

  assign dout  = mem_r[rd_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
endmodule
`default_nettype wire

FILE: rtl/rab_back.sv
// Back end: corner products, per-axis extremes, rounding, scale and shift.
// Depends on rab_pkg. Five register stages, one item per cycle.
`default_nettype none
module rab_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rab_pkg::rot_item_t in_item,
  input  rab_pkg::base_t     base,
  output logic               out_valid,
  output rab_pkg::q16_t [2:0] out_min,
  output rab_pkg::q16_t [2:0] out_max
);
  import rab_pkg::*;

  logic v_r [0:4];
  xf_t  xf_r [0:3];
  logic signed [PW-1:0] pl_r [0:8];
  logic signed [PW-1:0] ph_r [0:8];
  logic signed [SW-1:0] mn_r [0:2];
  logic signed [SW-1:0] mx_r [0:2];
  q16_t emn_r [0:2];
  q16_t emx_r [0:2];
  logic signed [63:0] qmn_r [0:2];
  logic signed [63:0] qmx_r [0:2];
  q16_t omn_r [0:2];
  q16_t omx_r [0:2];
  logic signed [PW-1:0] a_nxt, b_nxt;
  logic signed [SW-1:0] mn_nxt [0:2];
  logic signed [SW-1:0] mx_nxt [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 1; i < 5; i++) v_r[i] <= v_r[i-1];
    end
  end

  // corners separate per axis: extreme of the sum is the sum of per-term extremes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mn_nxt[i] = '0;
      mx_nxt[i] = '0;
      for (int j = 0; j < 3; j++) begin
        a_nxt = pl_r[3*i+j];
        b_nxt = ph_r[3*i+j];
        mn_nxt[i] = mn_nxt[i] + SW'((a_nxt < b_nxt) ? a_nxt : b_nxt);
        mx_nxt[i] = mx_nxt[i] + SW'((a_nxt < b_nxt) ? b_nxt : a_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    xf_r[0] <= in_item.xf;
    for (int i = 1; i < 4; i++) xf_r[i] <= xf_r[i-1];
    for (int k = 0; k < 9; k++) begin
      pl_r[k] <= PW'(in_item.r[k]) * PW'(base.lo[k%3]);
      ph_r[k] <= PW'(in_item.r[k]) * PW'(base.hi[k%3]);
    end
    for (int i = 0; i < 3; i++) begin
      mn_r[i]  <= mn_nxt[i];
      mx_r[i]  <= mx_nxt[i];
      emn_r[i] <= sat32((64'(mn_r[i]) + 64'sd32768) >>> 16);
      emx_r[i] <= sat32((64'(mx_r[i]) + 64'sd32768) >>> 16);
      qmn_r[i] <= 64'(emn_r[i]) * 64'(xf_r[2].scl[i]);
      qmx_r[i] <= 64'(emx_r[i]) * 64'(xf_r[2].scl[i]);
      omn_r[i] <= sat32(((qmn_r[i] + 64'sd32768) >>> 16) + 64'(xf_r[3].sh[i]));
      omx_r[i] <= sat32(((qmx_r[i] + 64'sd32768) >>> 16) + 64'(xf_r[3].sh[i]));
    end
  end

  assign out_valid = v_r[4];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_min[i] = omn_r[i];
      out_max[i] = omx_r[i];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rotated_aabb_refit_top.sv
// Rotated box refit: Euler xyz rotation of a configured box, refit, scale, shift.
// Throughput: one item per cycle while busy is low; set by the fully pipelined CORDIC and multipliers.
// out_valid strobes one cycle per item; the receiver cannot stall, results never wait.
// Synchronous active-low reset clears pipeline valids, the queue and the base box
// (min corner 0, max corner 1.0 in Q16.16). Depends on rab_pkg and all rab_ modules.
`default_nettype none
module rotated_aabb_refit_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rab_pkg::ang_t in_angle_x,
  input  rab_pkg::ang_t in_angle_y,
  input  rab_pkg::ang_t in_angle_z,
  input  rab_pkg::q16_t in_scale_x,
  input  rab_pkg::q16_t in_scale_y,
  input  rab_pkg::q16_t in_scale_z,
  input  rab_pkg::q16_t in_shift_x,
  input  rab_pkg::q16_t in_shift_y,
  input  rab_pkg::q16_t in_shift_z,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output logic          out_valid,
  output rab_pkg::q16_t out_world_min_x,
  output rab_pkg::q16_t out_world_min_y,
  output rab_pkg::q16_t out_world_min_z,
  output rab_pkg::q16_t out_world_max_x,
  output rab_pkg::q16_t out_world_max_y,
  output rab_pkg::q16_t out_world_max_z
);
  import rab_pkg::*;

  base_t     base_r;
  in_item_t  in_item;
  logic      f_valid;
  rot_item_t f_item, q_item;
  logic      q_push, q_pop, q_empty, q_full;
  q16_t [2:0] o_min, o_max;

  // base box registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r.lo <= '0;
      base_r.hi <= {3{32'sd65536}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_X: base_r.lo[0] <= cfg_data;
        CFG_MIN_Y: base_r.lo[1] <= cfg_data;
        CFG_MIN_Z: base_r.lo[2] <= cfg_data;
        CFG_MAX_X: base_r.hi[0] <= cfg_data;
        CFG_MAX_Y: base_r.hi[1] <= cfg_data;
        CFG_MAX_Z: base_r.hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.ang = {in_angle_z, in_angle_y, in_angle_x};
  assign in_item.xf.scl = {in_scale_z, in_scale_y, in_scale_x};
  assign in_item.xf.sh  = {in_shift_z, in_shift_y, in_shift_x};

  // back end drains every cycle, so the queue holds at most one item
  assign busy = q_full;

  rab_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(start && !busy), .in_item(in_item),
    .out_valid(f_valid), .out_item(f_item)
  );

  assign q_push = f_valid;
  assign q_pop  = !q_empty;

  rab_queue #(.W($bits(rot_item_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .din(f_item),
    .pop(q_pop), .dout(q_item),
    .empty(q_empty), .full(q_full)
  );

  rab_back u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q_pop), .in_item(q_item), .base(base_r),
    .out_valid(out_valid), .out_min(o_min), .out_max(o_max)
  );

  assign out_world_min_x = o_min[0];
  assign out_world_min_y = o_min[1];
  assign out_world_min_z = o_min[2];
  assign out_world_max_x = o_max[0];
  assign out_world_max_y = o_max[1];
  assign out_world_max_z = o_max[2];

  // a finished front-end item must always find room
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue overflow");

  // the queue only fills through a push, since the back end pops whenever non-empty
  a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> $past(q_push))
    else $error("queue full without push");
endmodule
`default_nettype wire
